[rtl/http_header_line_parser_macros.svh]
// ----------------------------------------------------------------------------
// http_header_line_parser_macros.svh
// Assertion macros for the header line parser; empty when SYNTHESIS is set.
// ----------------------------------------------------------------------------
`ifndef HTTP_HEADER_LINE_PARSER_MACROS_SVH
`define HTTP_HEADER_LINE_PARSER_MACROS_SVH
`ifndef SYNTHESIS
// property that holds at every edge outside reset
`define HHLP_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// condition now implies a consequence at the next edge
`define HHLP_ASSERT_NEXT(lbl, clk, rst, pre, post, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);
`else
`define HHLP_ASSERT(lbl, clk, rst, prop, msg)
`define HHLP_ASSERT_NEXT(lbl, clk, rst, pre, post, msg)
`endif
`endif

[rtl/hhlp_pkg.sv]
// ----------------------------------------------------------------------------
// hhlp_pkg
// Shared types and constants of the HTTP header line parser.
// ----------------------------------------------------------------------------
`default_nettype none

package hhlp_pkg;

   localparam int TOKEN_W = 14;

   localparam logic [7:0] CH_COLON = 8'h3A;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_SPACE = 8'h20;

   localparam logic [2:0] KIND_NAME     = 3'd0;
   localparam logic [2:0] KIND_NAME_END = 3'd1;
   localparam logic [2:0] KIND_VALUE    = 3'd2;
   localparam logic [2:0] KIND_LINE_END = 3'd3;
   localparam logic [2:0] KIND_HEAD_END = 3'd4;
   localparam logic [2:0] KIND_ERROR    = 3'd5;

   localparam logic [1:0] ERR_NO_NAME    = 2'd0;
   localparam logic [1:0] ERR_NAME_LONG  = 2'd1;
   localparam logic [1:0] ERR_NAME_CRLF  = 2'd2;
   localparam logic [1:0] ERR_VALUE_LONG = 2'd3;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic [2:0]         kind;
      logic [7:0]         data_byte;
      logic [TOKEN_W-1:0] lead_spaces;
      logic [1:0]         error_code;
      logic               last;
   } result_type;

   // results caused by one input byte
   typedef struct packed {
      result_type first;
      result_type second;
      logic       two;
   } entry_type;

endpackage

`default_nettype wire

[rtl/hhlp_front.sv]
// ----------------------------------------------------------------------------
// hhlp_front
// Per-byte classifier: parse state, token counts, held CR and spaces.
// ----------------------------------------------------------------------------
`default_nettype none
`include "http_header_line_parser_macros.svh"

module hhlp_front #(
   parameter int TOKEN_LIMIT = 8192
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        accept,
   input  wire logic [7:0]                  rx_byte,
   input  wire logic                        new_message,
   input  wire logic                        csr_valid,
   input  wire logic [hhlp_pkg::TOKEN_W-1:0] csr_max_token,
   output logic                             entry_valid,
   output hhlp_pkg::entry_type              entry
);

   localparam int CAP = (TOKEN_LIMIT > 16383) ? 16383 : TOKEN_LIMIT;
   localparam logic [hhlp_pkg::TOKEN_W-1:0] LIMIT_CAP = hhlp_pkg::TOKEN_W'(CAP);

   typedef enum logic [6:0] {
      PH_LINE    = 7'b0000001,
      PH_LINE_CR = 7'b0000010,
      PH_NAME    = 7'b0000100,
      PH_SKIP    = 7'b0001000,
      PH_VALUE   = 7'b0010000,
      PH_DONE    = 7'b0100000,
      PH_STOP    = 7'b1000000
   } phase_type;

   phase_type                      phase_ff, phase_in, cur;
   logic [hhlp_pkg::TOKEN_W-1:0]   name_count_ff, name_count_in;
   logic [hhlp_pkg::TOKEN_W-1:0]   value_count_ff, value_count_in;
   logic [hhlp_pkg::TOKEN_W-1:0]   held_spaces_ff, held_spaces_in;
   logic                           prev_cr_ff, prev_cr_in;
   logic                           held_cr_ff, held_cr_in;
   logic [hhlp_pkg::TOKEN_W-1:0]   limit_ff, limit_in;
   hhlp_pkg::result_type           res0, res1;
   logic [1:0]                     n;

   function automatic hhlp_pkg::result_type mk(input logic [2:0] kind,
                                               input logic [7:0] data,
                                               input logic [hhlp_pkg::TOKEN_W-1:0] lead,
                                               input logic [1:0] err);
      hhlp_pkg::result_type r;
      r.kind        = kind;
      r.data_byte   = data;
      r.lead_spaces = lead;
      r.error_code  = err;
      r.last        = 1'b0;
      return r;
   endfunction

   assign limit_in = (csr_max_token < LIMIT_CAP) ? csr_max_token : LIMIT_CAP;

   always_comb begin
      hhlp_pkg::result_type r;
      phase_in       = phase_ff;
      name_count_in  = name_count_ff;
      value_count_in = value_count_ff;
      prev_cr_in     = prev_cr_ff;
      held_cr_in     = held_cr_ff;
      held_spaces_in = held_spaces_ff;
      res0           = '0;
      res1           = '0;
      n              = 2'd0;
      r              = '0;
      if (new_message) begin
         phase_in       = PH_LINE;
         name_count_in  = '0;
         value_count_in = '0;
         prev_cr_in     = 1'b0;
         held_cr_in     = 1'b0;
         held_spaces_in = '0;
      end
      cur = phase_in;
      case (cur)
         PH_LINE: begin
            if (rx_byte == hhlp_pkg::CH_COLON) begin
               res0     = mk(hhlp_pkg::KIND_ERROR, 8'd0, '0, hhlp_pkg::ERR_NO_NAME);
               n        = 2'd1;
               phase_in = PH_STOP;
            end else if (rx_byte == hhlp_pkg::CH_CR) begin
               phase_in = PH_LINE_CR;
            end else if (limit_ff == '0) begin
               res0     = mk(hhlp_pkg::KIND_ERROR, 8'd0, '0, hhlp_pkg::ERR_NAME_LONG);
               n        = 2'd1;
               phase_in = PH_STOP;
            end else begin
               name_count_in = hhlp_pkg::TOKEN_W'(1);
               res0          = mk(hhlp_pkg::KIND_NAME, rx_byte, '0, 2'd0);
               n             = 2'd1;
               prev_cr_in    = 1'b0;
               phase_in      = PH_NAME;
            end
         end
         PH_LINE_CR: begin
            if (rx_byte == hhlp_pkg::CH_LF) begin
               res0     = mk(hhlp_pkg::KIND_HEAD_END, 8'd0, '0, 2'd0);
               n        = 2'd1;
               phase_in = PH_DONE;
            end else if (limit_ff == '0) begin
               res0     = mk(hhlp_pkg::KIND_ERROR, 8'd0, '0, hhlp_pkg::ERR_NAME_LONG);
               n        = 2'd1;
               phase_in = PH_STOP;
            end else begin
               // the held CR becomes the first name byte
               name_count_in = hhlp_pkg::TOKEN_W'(1);
               res0          = mk(hhlp_pkg::KIND_NAME, hhlp_pkg::CH_CR, '0, 2'd0);
               n             = 2'd2;
               prev_cr_in    = 1'b1;
               phase_in      = PH_NAME;
               if (rx_byte == hhlp_pkg::CH_COLON) begin
                  res1     = mk(hhlp_pkg::KIND_NAME_END, 8'd0, '0, 2'd0);
                  phase_in = PH_SKIP;
               end else if (limit_ff == hhlp_pkg::TOKEN_W'(1)) begin
                  res1     = mk(hhlp_pkg::KIND_ERROR, 8'd0, '0, hhlp_pkg::ERR_NAME_LONG);
                  phase_in = PH_STOP;
               end else begin
                  name_count_in = hhlp_pkg::TOKEN_W'(2);
                  res1          = mk(hhlp_pkg::KIND_NAME, rx_byte, '0, 2'd0);
                  prev_cr_in    = (rx_byte == hhlp_pkg::CH_CR);
               end
            end
         end
         PH_NAME: begin
            if (rx_byte == hhlp_pkg::CH_LF && prev_cr_in) begin
               res0     = mk(hhlp_pkg::KIND_ERROR, 8'd0, '0, hhlp_pkg::ERR_NAME_CRLF);
               n        = 2'd1;
               phase_in = PH_STOP;
            end else if (rx_byte == hhlp_pkg::CH_COLON) begin
               res0     = mk(hhlp_pkg::KIND_NAME_END, 8'd0, '0, 2'd0);
               n        = 2'd1;
               phase_in = PH_SKIP;
            end else if (name_count_in >= limit_ff) begin
               res0     = mk(hhlp_pkg::KIND_ERROR, 8'd0, '0, hhlp_pkg::ERR_NAME_LONG);
               n        = 2'd1;
               phase_in = PH_STOP;
            end else begin
               name_count_in = name_count_in + 1'b1;
               res0          = mk(hhlp_pkg::KIND_NAME, rx_byte, '0, 2'd0);
               n             = 2'd1;
               prev_cr_in    = (rx_byte == hhlp_pkg::CH_CR);
            end
         end
         PH_SKIP, PH_VALUE: begin
            if (cur == PH_SKIP) begin
               value_count_in = '0;
               held_cr_in     = 1'b0;
               held_spaces_in = '0;
            end
            if (cur == PH_SKIP && rx_byte == hhlp_pkg::CH_SPACE) begin
               phase_in = PH_SKIP;
            end else if (held_cr_in && rx_byte == hhlp_pkg::CH_LF) begin
               res0           = mk(hhlp_pkg::KIND_LINE_END, 8'd0, '0, 2'd0);
               n              = 2'd1;
               phase_in       = PH_LINE;
               name_count_in  = '0;
               value_count_in = '0;
               prev_cr_in     = 1'b0;
               held_cr_in     = 1'b0;
               held_spaces_in = '0;
            end else if (value_count_in >= limit_ff) begin
               res0     = mk(hhlp_pkg::KIND_ERROR, 8'd0, '0, hhlp_pkg::ERR_VALUE_LONG);
               n        = 2'd1;
               phase_in = PH_STOP;
            end else begin
               phase_in       = PH_VALUE;
               value_count_in = value_count_in + 1'b1;
               if (held_cr_in) begin
                  res0           = mk(hhlp_pkg::KIND_VALUE, hhlp_pkg::CH_CR,
                                      held_spaces_in, 2'd0);
                  n              = 2'd1;
                  held_spaces_in = '0;
                  held_cr_in     = 1'b0;
               end
               if (rx_byte == hhlp_pkg::CH_SPACE) begin
                  held_spaces_in = held_spaces_in + 1'b1;
               end else if (rx_byte == hhlp_pkg::CH_CR) begin
                  held_cr_in = 1'b1;
               end else begin
                  r = mk(hhlp_pkg::KIND_VALUE, rx_byte, held_spaces_in, 2'd0);
                  if (n == 2'd0) begin
                     res0 = r;
                  end else begin
                     res1 = r;
                  end
                  n              = n + 2'd1;
                  held_spaces_in = '0;
               end
            end
         end
         PH_DONE: begin
            phase_in = PH_DONE;
         end
         default: begin
            phase_in = PH_STOP;
         end
      endcase
      if (n == 2'd1) begin
         res0.last = 1'b1;
      end
      if (n == 2'd2) begin
         res1.last = 1'b1;
      end
   end

   assign entry_valid  = accept && (n != 2'd0);
   assign entry.first  = res0;
   assign entry.second = res1;
   assign entry.two    = (n == 2'd2);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_LINE;
         name_count_ff  <= '0;
         value_count_ff <= '0;
         prev_cr_ff     <= 1'b0;
         held_cr_ff     <= 1'b0;
         held_spaces_ff <= '0;
         limit_ff       <= LIMIT_CAP;
      end else begin
         if (accept) begin
            phase_ff       <= phase_in;
            name_count_ff  <= name_count_in;
            value_count_ff <= value_count_in;
            prev_cr_ff     <= prev_cr_in;
            held_cr_ff     <= held_cr_in;
            held_spaces_ff <= held_spaces_in;
         end
         if (csr_valid) begin
            limit_ff <= limit_in;
         end
      end
   end

   `HHLP_ASSERT_NEXT(a_stop_holds, clock, reset, phase_ff == PH_STOP && !(accept && new_message), phase_ff == PH_STOP, "parser left stop without new message")
   `HHLP_ASSERT(a_held_cr_phase, clock, reset, held_cr_ff |-> (phase_ff == PH_VALUE || phase_ff == PH_STOP), "held CR outside value")

endmodule

`default_nettype wire

[rtl/hhlp_queue.sv]
// ----------------------------------------------------------------------------
// hhlp_queue
// Short register queue of per-byte result entries between front and back.
// ----------------------------------------------------------------------------
`default_nettype none
`include "http_header_line_parser_macros.svh"

module hhlp_queue (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                wr_en,
   input  wire hhlp_pkg::entry_type wr_data,
   input  wire logic                rd_en,
   output logic                     full,
   output logic                     rd_valid,
   output hhlp_pkg::entry_type      rd_data
);

   localparam logic [hhlp_pkg::QCNT_W-1:0] DEPTH_CNT =
      hhlp_pkg::QCNT_W'(hhlp_pkg::QUEUE_DEPTH);

   hhlp_pkg::entry_type               mem_ff [hhlp_pkg::QUEUE_DEPTH];
   logic [hhlp_pkg::QPTR_W-1:0]       wr_ptr_ff, rd_ptr_ff;
   logic [hhlp_pkg::QCNT_W-1:0]       count_ff, count_in;

   assign full     = (count_ff == DEPTH_CNT);
   assign rd_valid = (count_ff != '0);
   assign rd_data  = mem_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (wr_en && !rd_en) begin
         count_in = count_ff + 1'b1;
      end else if (!wr_en && rd_en) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (wr_en) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (rd_en) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         count_ff <= count_in;
      end
   end

   `HHLP_ASSERT(a_count_range, clock, reset, count_ff <= DEPTH_CNT, "queue count out of range")
   `HHLP_ASSERT(a_no_underflow, clock, reset, !(rd_en && count_ff == '0), "read from empty queue")
   `HHLP_ASSERT_NEXT(a_count_up, clock, reset, wr_en && !rd_en, count_ff == $past(count_ff) + 1'b1, "queue count missed a write")

endmodule

`default_nettype wire

[rtl/hhlp_back.sv]
// ----------------------------------------------------------------------------
// hhlp_back
// Result side: holds one entry and hands out its results one per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

module hhlp_back (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                q_valid,
   input  wire hhlp_pkg::entry_type q_data,
   output logic                     q_rd,
   input  wire logic                pop,
   output logic                     empty,
   output hhlp_pkg::result_type     result
);

   hhlp_pkg::entry_type ent_ff;
   logic                valid_ff;
   logic                sel_ff;
   logic                advance;
   logic                step_second;

   assign advance     = pop && valid_ff;
   assign step_second = advance && !sel_ff && ent_ff.two;
   assign q_rd        = q_valid && (!valid_ff || (advance && !step_second));
   assign empty       = !valid_ff;
   assign result      = sel_ff ? ent_ff.second : ent_ff.first;

   always_ff @(posedge clock) begin
      if (q_rd) begin
         ent_ff <= q_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         sel_ff   <= 1'b0;
      end else if (step_second) begin
         sel_ff <= 1'b1;
      end else if (!valid_ff || advance) begin
         valid_ff <= q_valid;
         sel_ff   <= 1'b0;
      end
   end

endmodule

`default_nettype wire

[rtl/http_header_line_parser.sv]
// ----------------------------------------------------------------------------
// http_header_line_parser
// Path: a pushed byte's results pass through the queue, then the back output register, to the result ports.
// Throughput: one byte per cycle in while the queue is not full; one result transaction per cycle out while not empty.
// Bytes that cause two results hold the output side for two transactions; the queue absorbs it.
// Reset (synchronous, active high): line start, counts cleared, max_token = limit.
// ----------------------------------------------------------------------------
`default_nettype none

// Structure:
//   front - parses each accepted byte combinationally against the parse state
//           and writes zero, one or two results as a single queue entry.
//   queue - four entries of per-byte results; full stalls push.
//   back  - output register; pops entries and serves their results in order,
//           the second result of an entry one transaction after the first.
// The input side accepts every cycle while the queue has room, so a waiting
// result never blocks the next byte until the queue fills.
//
// Value handling notes:
//   - trailing spaces are held as a count and travel as lead_spaces with the
//     next real value byte; pending spaces at CR LF are dropped.
//   - a CR in a value is held; CR LF ends the line, anything else releases
//     the CR as a value byte ahead of the new byte.
//   - the limit in force is min(max_token, TOKEN_LIMIT), folded at write time.

module http_header_line_parser #(
   parameter int TOKEN_LIMIT = 8192
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   // input channel
   input  wire logic                         push,
   output logic                              full,
   input  wire logic [7:0]                   req_rx_byte,
   input  wire logic                         req_new_message,
   // result channel
   output logic                              empty,
   input  wire logic                         pop,
   output logic [2:0]                        rsp_kind,
   output logic [7:0]                        rsp_data_byte,
   output logic [hhlp_pkg::TOKEN_W-1:0]      rsp_lead_spaces,
   output logic [1:0]                        rsp_error_code,
   output logic                              rsp_last,
   // configuration write channel
   input  wire logic                         csr_valid,
   output logic                              csr_ready,
   input  wire logic [hhlp_pkg::TOKEN_W-1:0] csr_max_token
);

   logic                 accept;
   logic                 entry_valid;
   hhlp_pkg::entry_type  entry;
   logic                 q_rd;
   logic                 q_valid;
   hhlp_pkg::entry_type  q_data;
   hhlp_pkg::result_type result;

   // transaction on the input side
   assign accept    = push && !full;
   // register writes take effect in the cycle after they are presented; always ready
   assign csr_ready = 1'b1;

   hhlp_front #(
      .TOKEN_LIMIT (TOKEN_LIMIT)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .rx_byte       (req_rx_byte),
      .new_message   (req_new_message),
      .csr_valid     (csr_valid),
      .csr_max_token (csr_max_token),
      .entry_valid   (entry_valid),
      .entry         (entry)
   );

   hhlp_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (entry_valid),
      .wr_data  (entry),
      .rd_en    (q_rd),
      .full     (full),
      .rd_valid (q_valid),
      .rd_data  (q_data)
   );

   hhlp_back u_back (
      .clock   (clock),
      .reset   (reset),
      .q_valid (q_valid),
      .q_data  (q_data),
      .q_rd    (q_rd),
      .pop     (pop),
      .empty   (empty),
      .result  (result)
   );

   assign rsp_kind        = result.kind;
   assign rsp_data_byte   = result.data_byte;
   assign rsp_lead_spaces = result.lead_spaces;
   assign rsp_error_code  = result.error_code;
   assign rsp_last        = result.last;

endmodule

`default_nettype wire
